>>> rtl/grwi_pkg.sv
// shared types, constants and codes for the grid ray wall intersection block
package grwi_pkg;

   // parameter defaults
   localparam int MAP_CELLS_DEF = 4096;
   localparam int MAX_STEPS_DEF = 128;
   localparam int FRAC_BITS_DEF = 10;

   // item commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_CAST  = 1'b1;

   // configuration register indexes
   localparam logic REG_MAP_WIDTH  = 1'b0;
   localparam logic REG_MAP_HEIGHT = 1'b1;

   // divider job kinds
   localparam logic DIV_FIRST = 1'b0;
   localparam logic DIV_STEP  = 1'b1;

   // search select
   localparam logic SEL_HORIZ = 1'b0;
   localparam logic SEL_VERT  = 1'b1;

   // reset value of the map size registers
   localparam logic [6:0] MAP_SIZE_RESET = 7'd64;

   typedef struct packed {
      logic               cmd;
      logic [11:0]        cell_index;
      logic [7:0]         cell_value;
      logic [15:0]        pos_x;
      logic [15:0]        pos_y;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] hit_dx;
      logic signed [31:0] hit_dy;
      logic               hit_horizontal;
      logic               no_hit;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic       clr_en;
      logic       wr_en;
      logic       sel_v;
      logic       load_search;
      logic       div_start;
      logic       div_kind;
      logic       advance;
      logic       hit_store;
      logic       miss_store;
      logic       sq_en;
      logic [2:0] sq_phase;
      logic       out_load;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clr_last;
      logic dp_zero;
      logic div_done;
      logic cell_hit;
   } stat_type;

endpackage

>>> rtl/grwi_ram.sv
// generic simple dual port ram with registered read
module grwi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/grwi_div.sv
// iterative signed floor divider, one quotient bit per cycle
module grwi_div #(
   parameter int NW = 27,
   parameter int DW = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [NW-1:0] num,
   input  logic [DW-1:0]        den,
   output logic                 done,
   output logic signed [NW:0]   quo,
   output logic [DW-1:0]        rem
);

   localparam int CNW = $clog2(NW + 1);

   logic           busy_ff, busy_in;
   logic           fix_ff, fix_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0]  mag_ff, mag_in;
   logic [DW:0]    rem_ff, rem_in;
   logic [DW-1:0]  den_ff, den_in;
   logic           neg_ff, neg_in;
   logic [DW:0]    trial;

   // restoring step and job start
   always_comb begin
      busy_in = busy_ff;
      fix_in  = 1'b0;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff[DW-1:0], mag_ff[NW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNW'(NW);
         mag_in  = num[NW-1] ? NW'(-num) : NW'(num);
         rem_in  = '0;
         den_in  = den;
         neg_in  = num[NW-1];
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            mag_in = {mag_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            mag_in = {mag_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNW'(1);
         if (cnt_ff == CNW'(1)) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // turn truncated magnitude result into floor quotient and remainder
   always_comb begin
      done = fix_ff;
      if (neg_ff && (rem_ff[DW-1:0] != '0)) begin
         quo = ~$signed({1'b0, mag_ff});
         rem = den_ff - rem_ff[DW-1:0];
      end else if (neg_ff) begin
         quo = -$signed({1'b0, mag_ff});
         rem = rem_ff[DW-1:0];
      end else begin
         quo = $signed({1'b0, mag_ff});
         rem = rem_ff[DW-1:0];
      end
   end

endmodule

>>> rtl/grwi_ctrl.sv
// sequencer for map clear, cell writes, the two grid line searches and the length compare
module grwi_ctrl #(
   parameter int MAX_STEPS = grwi_pkg::MAX_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_cmd,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  grwi_pkg::stat_type stat,
   output grwi_pkg::cmd_type  cmd
);

   localparam int SW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

   typedef enum logic [9:0] {
      ST_CLR   = 10'b0000000001,
      ST_IDLE  = 10'b0000000010,
      ST_WR    = 10'b0000000100,
      ST_SETUP = 10'b0000001000,
      ST_DIV0  = 10'b0000010000,
      ST_DIV1  = 10'b0000100000,
      ST_STEP  = 10'b0001000000,
      ST_CHECK = 10'b0010000000,
      ST_SQ    = 10'b0100000000,
      ST_DONE  = 10'b1000000000
   } state_type;

   state_type      state_ff, state_in;
   logic [SW-1:0]  k_ff, k_in;
   logic           sel_ff, sel_in;
   logic [2:0]     phase_ff, phase_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           search_end;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      sel_in     = sel_ff;
      phase_in   = phase_ff;
      req_ready  = 1'b0;
      search_end = 1'b0;
      cmd        = '0;
      cmd.sel_v    = sel_ff;
      cmd.sq_phase = phase_ff;
      case (state_ff)
         ST_CLR: begin
            cmd.clr_en = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            sel_in    = grwi_pkg::SEL_HORIZ;
            if (req_valid) begin
               state_in = (req_cmd == grwi_pkg::CMD_CAST) ? ST_SETUP : ST_WR;
            end
         end
         ST_WR: begin
            cmd.wr_en = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_SETUP: begin
            if (stat.dp_zero) begin
               cmd.miss_store = 1'b1;
               search_end     = 1'b1;
            end else begin
               cmd.load_search = 1'b1;
               cmd.div_start   = 1'b1;
               cmd.div_kind    = grwi_pkg::DIV_FIRST;
               state_in        = ST_DIV0;
            end
         end
         ST_DIV0: begin
            if (stat.div_done) begin
               cmd.div_start = 1'b1;
               cmd.div_kind  = grwi_pkg::DIV_STEP;
               state_in      = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (stat.div_done) begin
               k_in     = '0;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.cell_hit) begin
               cmd.hit_store = 1'b1;
               search_end    = 1'b1;
            end else if (k_ff == SW'(MAX_STEPS - 1)) begin
               cmd.miss_store = 1'b1;
               search_end     = 1'b1;
            end else begin
               cmd.advance = 1'b1;
               k_in        = k_ff + SW'(1);
               state_in    = ST_STEP;
            end
         end
         ST_SQ: begin
            cmd.sq_en = 1'b1;
            phase_in  = phase_ff + 3'd1;
            if (phase_ff == 3'd4) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // move on to the vertical search or to the compare
      if (search_end) begin
         if (sel_ff == grwi_pkg::SEL_HORIZ) begin
            sel_in   = grwi_pkg::SEL_VERT;
            state_in = ST_SETUP;
         end else begin
            phase_in = 3'd0;
            state_in = ST_SQ;
         end
      end
   end

   // output slot flag
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         k_ff         <= '0;
         sel_ff       <= grwi_pkg::SEL_HORIZ;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         sel_ff       <= sel_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/grwi_dp.sv
// datapath: map memory, slope divider, crossing walk, hit compare and result register
module grwi_dp #(
   parameter int MAP_CELLS = grwi_pkg::MAP_CELLS_DEF,
   parameter int MAX_STEPS = grwi_pkg::MAX_STEPS_DEF,
   parameter int FRAC_BITS = grwi_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  grwi_pkg::req_type  req_data,
   input  logic               csr_fire,
   input  logic               csr_index,
   input  logic [6:0]         csr_data,
   input  grwi_pkg::cmd_type  cmd,
   output grwi_pkg::stat_type stat,
   output grwi_pkg::rsp_type  rsp_data
);

   localparam int AW  = $clog2(MAP_CELLS);
   localparam int IW  = (AW > 14) ? AW : 14;
   localparam int SW  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int PW  = (((FRAC_BITS + SW) > 16) ? (FRAC_BITS + SW) : 16) + 3;
   localparam int NW  = FRAC_BITS + 17;
   localparam int QDW = NW + 1;
   localparam int QW  = PW + 17;
   localparam int CW  = QW + 2;
   localparam logic [FRAC_BITS:0] ONE_U = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic signed [PW-1:0] ONE_P = PW'(ONE_U);
   localparam logic signed [CW-1:0] SAT_MAX = {{(CW-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [CW-1:0] SAT_MIN = {{(CW-31){1'b1}}, {31{1'b0}}};

   grwi_pkg::req_type req_ff;
   grwi_pkg::rsp_type rsp_ff;
   logic [6:0]         width_ff, height_ff;
   logic [AW-1:0]      clr_addr_ff;
   logic               kind_ff;
   logic signed [PW-1:0] op_ff;
   logic signed [QW-1:0] q_ff, qd_ff;
   logic [16:0]        r_ff;
   logic [15:0]        rd_ff;
   logic               rd_ok_ff;
   logic               hh_ff, vh_ff;
   logic signed [31:0] hx_ff, hy_ff, vx_ff, vy_ff;
   logic [63:0]        sq_ff, hl_ff, vl_ff;

   // sign-extended saturation to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [CW-1:0] v);
      logic signed [31:0] res;
      if (v > SAT_MAX) begin
         res = 32'sh7fffffff;
      end else if (v < SAT_MIN) begin
         res = 32'sh80000000;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

   // clamp a cell coordinate to the map edge
   function automatic logic [6:0] clamp_c(input logic signed [CW-1:0] c,
                                          input logic [6:0] n);
      logic [6:0] res;
      if (c[CW-1]) begin
         res = 7'd0;
      end else if (c >= $signed({{(CW-7){1'b0}}, n})) begin
         res = n - 7'd1;
      end else begin
         res = c[6:0];
      end
      return res;
   endfunction

   // operands of the active search
   logic [15:0]          pp, ps;
   logic signed [15:0]   dpd, dsd;
   logic                 dneg, dsneg;
   logic [FRAC_BITS:0]   frac_ext, mag_first;
   logic signed [FRAC_BITS+17:0] prod0;
   logic signed [NW-1:0] num0, num1, div_num;
   logic [15:0]          den;
   logic signed [PW-1:0] first_s;

   always_comb begin
      if (cmd.sel_v == grwi_pkg::SEL_HORIZ) begin
         pp  = req_ff.pos_y;
         ps  = req_ff.pos_x;
         dpd = req_ff.dir_y;
         dsd = req_ff.dir_x;
      end else begin
         pp  = req_ff.pos_x;
         ps  = req_ff.pos_y;
         dpd = req_ff.dir_x;
         dsd = req_ff.dir_y;
      end
      dneg      = dpd[15];
      dsneg     = dsd[15];
      frac_ext  = {1'b0, pp[FRAC_BITS-1:0]};
      mag_first = dneg ? frac_ext : (ONE_U - frac_ext);
      first_s   = dneg ? -$signed(PW'(mag_first)) : $signed(PW'(mag_first));
      prod0     = $signed({1'b0, mag_first}) * dsd;
      num0      = prod0[NW-1:0];
      num1      = {dsd[15], dsd, {FRAC_BITS{1'b0}}};
      div_num   = (cmd.div_kind == grwi_pkg::DIV_STEP) ? num1 : num0;
      den       = dneg ? 16'(-dpd) : 16'(dpd);
   end

   // slope divider
   logic                  div_done;
   logic signed [QDW-1:0] div_quo;
   logic [15:0]           div_rem;

   grwi_div #(
      .NW (NW),
      .DW (16)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (den),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // crossing position and cell address
   logic signed [QW-1:0] os;
   logic signed [CW-1:0] psum, ppsum, cs_w, cp_w;
   logic [6:0]           w_eff, h_eff, cx, cy;
   logic [13:0]          row_off;
   logic [IW-1:0]        idx, wr_idx;
   logic                 idx_ok, wr_ok;
   logic [16:0]          rsum;

   always_comb begin
      w_eff   = (width_ff == 7'd0) ? 7'd1 : width_ff;
      h_eff   = (height_ff == 7'd0) ? 7'd1 : height_ff;
      os      = q_ff + QW'({dsneg && (r_ff != 17'd0)});
      psum    = CW'($signed({1'b0, ps})) + CW'(os);
      ppsum   = CW'($signed({1'b0, pp})) + CW'(op_ff);
      cs_w    = psum >>> FRAC_BITS;
      cp_w    = (ppsum >>> FRAC_BITS) - $signed({{(CW-1){1'b0}}, dneg});
      if (cmd.sel_v == grwi_pkg::SEL_HORIZ) begin
         cx = clamp_c(cs_w, w_eff);
         cy = clamp_c(cp_w, h_eff);
      end else begin
         cx = clamp_c(cp_w, w_eff);
         cy = clamp_c(cs_w, h_eff);
      end
      row_off = cy * w_eff;
      idx     = IW'(cx) + IW'(row_off);
      idx_ok  = ({1'b0, idx} < (IW+1)'(MAP_CELLS));
      wr_idx  = IW'(req_ff.cell_index);
      wr_ok   = ({1'b0, wr_idx} < (IW+1)'(MAP_CELLS));
      rsum    = r_ff + {1'b0, rd_ff};
   end

   // map memory
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata, ram_rdata;

   always_comb begin
      ram_we    = cmd.clr_en || (cmd.wr_en && wr_ok);
      ram_waddr = cmd.clr_en ? clr_addr_ff : wr_idx[AW-1:0];
      ram_wdata = cmd.clr_en ? 8'd0 : req_ff.cell_value;
   end

   grwi_ram #(
      .WIDTH (8),
      .DEPTH (MAP_CELLS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (idx[AW-1:0]),
      .rd_data (ram_rdata)
   );

   // control registers: config and clear sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= grwi_pkg::MAP_SIZE_RESET;
         height_ff   <= grwi_pkg::MAP_SIZE_RESET;
         clr_addr_ff <= '0;
      end else begin
         if (csr_fire && (csr_index == grwi_pkg::REG_MAP_WIDTH)) begin
            width_ff <= csr_data;
         end
         if (csr_fire && (csr_index == grwi_pkg::REG_MAP_HEIGHT)) begin
            height_ff <= csr_data;
         end
         if (cmd.clr_en) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
         end
      end
   end

   // transaction latch, search walk and divider results
   always_ff @(posedge clock) begin
      rd_ok_ff <= idx_ok;
      if (req_fire) begin
         req_ff <= req_data;
      end
      if (cmd.div_start) begin
         kind_ff <= cmd.div_kind;
      end
      if (cmd.load_search) begin
         op_ff <= first_s;
      end else if (cmd.advance) begin
         op_ff <= op_ff + (dneg ? -ONE_P : ONE_P);
      end
      if (div_done && (kind_ff == grwi_pkg::DIV_STEP)) begin
         qd_ff <= QW'(div_quo);
         rd_ff <= div_rem;
      end else if (div_done) begin
         q_ff <= QW'(div_quo);
         r_ff <= {1'b0, div_rem};
      end else if (cmd.advance) begin
         if (rsum >= {1'b0, den}) begin
            r_ff <= rsum - {1'b0, den};
            q_ff <= q_ff + qd_ff + QW'(1);
         end else begin
            r_ff <= rsum;
            q_ff <= q_ff + qd_ff;
         end
      end
   end

   // hit records
   always_ff @(posedge clock) begin
      if (cmd.hit_store && (cmd.sel_v == grwi_pkg::SEL_HORIZ)) begin
         hh_ff <= 1'b1;
         hy_ff <= sat32(CW'(op_ff));
         hx_ff <= sat32(CW'(os));
      end else if (cmd.hit_store) begin
         vh_ff <= 1'b1;
         vx_ff <= sat32(CW'(op_ff));
         vy_ff <= sat32(CW'(os));
      end else if (cmd.miss_store && (cmd.sel_v == grwi_pkg::SEL_HORIZ)) begin
         hh_ff <= 1'b0;
      end else if (cmd.miss_store) begin
         vh_ff <= 1'b0;
      end
   end

   // squared lengths, one multiply per cycle
   logic signed [31:0] sq_op;
   logic signed [63:0] sq_prod;

   always_comb begin
      case (cmd.sq_phase)
         3'd0:    sq_op = hx_ff;
         3'd1:    sq_op = hy_ff;
         3'd2:    sq_op = vx_ff;
         default: sq_op = vy_ff;
      endcase
      sq_prod = sq_op * sq_op;
   end

   always_ff @(posedge clock) begin
      if (cmd.sq_en) begin
         sq_ff <= sq_prod;
         case (cmd.sq_phase)
            3'd1:    hl_ff <= sq_ff;
            3'd2:    hl_ff <= hl_ff + sq_ff;
            3'd3:    vl_ff <= sq_ff;
            3'd4:    vl_ff <= vl_ff + sq_ff;
            default: hl_ff <= hl_ff;
         endcase
      end
   end

   // result register
   logic pick_h, any_hit;

   always_comb begin
      any_hit = hh_ff || vh_ff;
      pick_h  = (hh_ff && vh_ff) ? (hl_ff < vl_ff) : hh_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.hit_dx         <= !any_hit ? 32'sd0 : (pick_h ? hx_ff : vx_ff);
         rsp_ff.hit_dy         <= !any_hit ? 32'sd0 : (pick_h ? hy_ff : vy_ff);
         rsp_ff.hit_horizontal <= any_hit && pick_h;
         rsp_ff.no_hit         <= !any_hit;
      end
   end

   always_comb begin
      stat.clr_last = (clr_addr_ff == AW'(MAP_CELLS - 1));
      stat.dp_zero  = (dpd == 16'sd0);
      stat.div_done = div_done;
      stat.cell_hit = rd_ok_ff && (ram_rdata != 8'd0);
   end

   assign rsp_data = rsp_ff;

endmodule

>>> rtl/grid_ray_wall_intersection.sv
// top level of the grid ray wall intersection block
//
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid/req_ready  | req_data (cell write or ray cast)
//  rsp_    | out       | rsp_valid/rsp_ready  | rsp_data (hit offsets and flags)
//  csr_    | in        | csr_valid/csr_ready  | csr_index, csr_data (map size)
//
// after reset the map memory is swept to zero, no request taken
// a cell write goes through its own write state; a cast gives one response, a write none
// each search: two slope divisions in the bit-serial divider, then one registered
// map ram read per grid crossing tested, at most MAX_STEPS crossings per search
// the compare of the two squared hit lengths follows the searches
// a finished response waits in its own register; the next transaction is taken meanwhile
module grid_ray_wall_intersection #(
   parameter int MAP_CELLS = grwi_pkg::MAP_CELLS_DEF,
   parameter int MAX_STEPS = grwi_pkg::MAX_STEPS_DEF,
   parameter int FRAC_BITS = grwi_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  grwi_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output grwi_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [6:0]        csr_data
);

   grwi_pkg::cmd_type  cmd;
   grwi_pkg::stat_type stat;
   logic               req_fire;
   logic               csr_fire;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_fire  = req_valid && req_ready;

   grwi_ctrl #(
      .MAX_STEPS (MAX_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   grwi_dp #(
      .MAP_CELLS (MAP_CELLS),
      .MAX_STEPS (MAX_STEPS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_data  (req_data),
      .csr_fire  (csr_fire),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

   // a waiting response is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("response register overwritten");

   // a miss response carries zero offsets
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.no_hit) |->
         (rsp_data.hit_dx == 32'sd0 && rsp_data.hit_dy == 32'sd0 && !rsp_data.hit_horizontal))
      else $error("miss response with nonzero fields");

   // the divider never finishes right after a start
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !stat.div_done)
      else $error("divider done too early");

   // no request taken while the map is being cleared
   assert property (@(posedge clock) disable iff (reset)
      cmd.clr_en |-> !req_ready)
      else $error("request taken during map clear");

endmodule
